>>> design/assembly_line_lexer_top_assert.svh
// Assertion macros shared by the lexer checker.
`ifndef ASSEMBLY_LINE_LEXER_TOP_ASSERT_SVH
`define ASSEMBLY_LINE_LEXER_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASMLEX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASMLEX_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/asmlex_pkg.sv
// Types, character constants and helpers shared by the lexer modules.
package asmlex_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_STRING  = 3'd4
    } asmlex_mode_t;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_APPEND = 2'd1,
        EV_END    = 2'd2
    } asmlex_kind_t;

    typedef enum logic [1:0] {
        CLS_PUNCT  = 2'd0,
        CLS_IDENT  = 2'd1,
        CLS_NUMBER = 2'd2,
        CLS_STRING = 2'd3
    } asmlex_class_t;

    typedef struct packed {
        asmlex_kind_t  kind;
        asmlex_class_t cls;
        logic [7:0]    ch;
        logic          has;
    } asmlex_ev_t;

    localparam int MAX_EVENTS = 3;

    // All events caused by one character, in emission order.
    typedef struct packed {
        logic [1:0]                      count;
        asmlex_ev_t [MAX_EVENTS-1:0]     ev;
    } asmlex_bundle_t;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic asmlex_ev_t mk_ev(input asmlex_kind_t kind, input asmlex_class_t cls,
                                         input logic [7:0] ch, input logic has);
        asmlex_ev_t e;
        e.kind = kind;
        e.cls  = cls;
        e.ch   = has ? ch : 8'h00;
        e.has  = has;
        return e;
    endfunction

endpackage

>>> design/asmlex_front.sv
// Front end: accepts characters, tracks the lexer mode and builds event bundles.
module asmlex_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  logic [7:0]                 char_in,
    input  logic                       line_end,
    input  logic                       q_full,
    output logic                       q_push,
    output asmlex_pkg::asmlex_bundle_t q_data
);
    import asmlex_pkg::*;

    asmlex_mode_t   mode_reg, mode_next;
    logic           single_reg, single_next;
    logic           bslash_reg, bslash_next;
    logic           accept;
    logic           redo;
    logic [1:0]     n;
    logic [7:0]     quote;
    asmlex_bundle_t bun;

    assign char_stall = q_full;
    assign accept     = char_valid && !q_full;

    always_comb
    begin
        mode_next   = mode_reg;
        single_next = single_reg;
        bslash_next = bslash_reg;
        bun         = '0;
        n           = 2'd0;
        redo        = 1'b0;
        quote       = single_reg ? CH_SQUOTE : CH_DQUOTE;

        unique case (mode_reg)
            MODE_COMMENT:
            begin
            end
            MODE_STRING:
            begin
                if ((char_in == quote) && !bslash_reg)
                begin
                    bun.ev[n]   = mk_ev(EV_END, CLS_STRING, 8'h00, 1'b0);
                    n           = n + 2'd1;
                    mode_next   = MODE_IDLE;
                    bslash_next = 1'b0;
                end
                else
                begin
                    bun.ev[n]   = mk_ev(EV_APPEND, CLS_STRING, char_in, 1'b1);
                    n           = n + 2'd1;
                    bslash_next = (char_in == CH_BSLASH);
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(char_in) || is_digit(char_in) || (char_in == CH_UNDER))
                begin
                    bun.ev[n] = mk_ev(EV_APPEND, CLS_IDENT, char_in, 1'b1);
                    n         = n + 2'd1;
                end
                else
                begin
                    bun.ev[n] = mk_ev(EV_END, CLS_IDENT, 8'h00, 1'b0);
                    n         = n + 2'd1;
                    mode_next = MODE_IDLE;
                    redo      = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(char_in))
                begin
                    bun.ev[n] = mk_ev(EV_APPEND, CLS_NUMBER, char_in, 1'b1);
                    n         = n + 2'd1;
                end
                else
                begin
                    bun.ev[n] = mk_ev(EV_END, CLS_NUMBER, 8'h00, 1'b0);
                    n         = n + 2'd1;
                    mode_next = MODE_IDLE;
                    redo      = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                redo      = 1'b1;
            end
        endcase

        // Characters seen in idle and ones closing an identifier or number start afresh.
        if (redo)
        begin
            if (char_in == CH_HASH)
            begin
                mode_next = MODE_COMMENT;
            end
            else if ((char_in == CH_SPACE) || (char_in == CH_TAB))
            begin
            end
            else if ((char_in == CH_DQUOTE) || (char_in == CH_SQUOTE))
            begin
                bun.ev[n]   = mk_ev(EV_START, CLS_STRING, 8'h00, 1'b0);
                n           = n + 2'd1;
                mode_next   = MODE_STRING;
                single_next = (char_in == CH_SQUOTE);
                bslash_next = 1'b0;
            end
            else if (is_alpha(char_in) || (char_in == CH_UNDER))
            begin
                bun.ev[n] = mk_ev(EV_START, CLS_IDENT, char_in, 1'b1);
                n         = n + 2'd1;
                mode_next = MODE_IDENT;
            end
            else if ((char_in == CH_MINUS) || is_digit(char_in))
            begin
                bun.ev[n] = mk_ev(EV_START, CLS_NUMBER, char_in, 1'b1);
                n         = n + 2'd1;
                mode_next = MODE_NUMBER;
            end
            else
            begin
                bun.ev[n] = mk_ev(EV_START, CLS_PUNCT, char_in, 1'b1);
                n         = n + 2'd1;
                bun.ev[n] = mk_ev(EV_END, CLS_PUNCT, 8'h00, 1'b0);
                n         = n + 2'd1;
            end
        end

        // The end of a line closes whatever token is still open.
        if (line_end)
        begin
            if (mode_next == MODE_IDENT)
            begin
                bun.ev[n] = mk_ev(EV_END, CLS_IDENT, 8'h00, 1'b0);
                n         = n + 2'd1;
            end
            else if (mode_next == MODE_NUMBER)
            begin
                bun.ev[n] = mk_ev(EV_END, CLS_NUMBER, 8'h00, 1'b0);
                n         = n + 2'd1;
            end
            else if (mode_next == MODE_STRING)
            begin
                bun.ev[n] = mk_ev(EV_END, CLS_STRING, 8'h00, 1'b0);
                n         = n + 2'd1;
            end
            mode_next   = MODE_IDLE;
            bslash_next = 1'b0;
        end

        bun.count = n;
    end

    assign q_push = accept && (n != 2'd0);
    assign q_data = bun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            single_reg <= 1'b0;
            bslash_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            single_reg <= single_next;
            bslash_reg <= bslash_next;
        end
    end

endmodule

>>> design/asmlex_queue.sv
// Short queue of event bundles between the front and back ends.
module asmlex_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  asmlex_pkg::asmlex_bundle_t push_data,
    output logic                       full,
    output logic                       not_empty,
    output asmlex_pkg::asmlex_bundle_t head,
    input  logic                       pop
);
    import asmlex_pkg::*;

    asmlex_bundle_t       mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/asmlex_back.sv
// Back end: issues bundle events one per cycle unless stalled, through an output register.
module asmlex_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  asmlex_pkg::asmlex_bundle_t q_head,
    output logic                       q_pop,
    output logic                       tok_valid,
    input  logic                       tok_stall,
    output logic [1:0]                 event_res,
    output logic [1:0]                 token_class,
    output logic [7:0]                 char_out,
    output logic                       has_char,
    output logic                       last
);
    import asmlex_pkg::*;

    logic [1:0]  sub_reg, sub_next;
    logic        valid_reg, valid_next;
    asmlex_ev_t  ev_reg;
    logic        last_reg;
    logic        load;
    logic        is_last;

    assign load    = q_valid && (!valid_reg || !tok_stall);
    assign is_last = (sub_reg == (q_head.count - 2'd1));
    assign q_pop   = load && is_last;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg && tok_stall;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = is_last ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg   <= q_head.ev[sub_reg];
            last_reg <= is_last;
        end
    end

    assign tok_valid   = valid_reg;
    assign event_res   = ev_reg.kind;
    assign token_class = ev_reg.cls;
    assign char_out    = ev_reg.ch;
    assign has_char    = ev_reg.has;
    assign last        = last_reg;

endmodule

>>> design/assembly_line_lexer_top.sv
// Streaming assembly-line lexer: characters in, token events out.
//
// Input channel (char_valid / char_stall): one source byte per request with
// line_end set on the last byte of a line. Output channel (tok_valid /
// tok_stall): one token event per request, with last set on the final event
// caused by a character. Separators and comment text produce no event.
// The first event of a character is written into the bundle queue when the
// character is taken and then passes through the output register.
// Throughput: one character per cycle while each character causes at most one
// event and tok_stall is low; a character causing several events issues them
// one at a time, and the four-entry bundle queue between front and back ends
// absorbs such runs. The output register issues at most one event per cycle.
// char_stall rises only when the bundle queue is full, which happens when the
// receiver holds tok_stall high or a long run of multi-event characters
// arrives. A stalled output event holds steady until it is taken.
// Reset returns the lexer to idle, empties the queue and clears tok_valid.
module assembly_line_lexer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_in,
    input  logic       line_end,
    output logic       tok_valid,
    input  logic       tok_stall,
    output logic [1:0] event_res,
    output logic [1:0] token_class,
    output logic [7:0] char_out,
    output logic       has_char,
    output logic       last
);
    import asmlex_pkg::*;

    logic           q_push;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    asmlex_bundle_t q_wdata;
    asmlex_bundle_t q_head;

    asmlex_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_in    (char_in),
        .line_end   (line_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    asmlex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop)
    );

    asmlex_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .event_res   (event_res),
        .token_class (token_class),
        .char_out    (char_out),
        .has_char    (has_char),
        .last        (last)
    );

endmodule

>>> design/asmlex_checker.sv
// Port-level checks on the lexer top level, bound into it.
`include "assembly_line_lexer_top_assert.svh"

module asmlex_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tok_valid,
    input logic       tok_stall,
    input logic [1:0] event_res,
    input logic [1:0] token_class,
    input logic [7:0] char_out,
    input logic       has_char,
    input logic       last
);
    import asmlex_pkg::*;

    `ASMLEX_ASSERT_RST(a_idle_in_reset, !rst_n |-> !tok_valid, "token valid during reset")

    `ASMLEX_ASSERT(a_hold_when_stalled,
        tok_valid && tok_stall |=> tok_valid && $stable(event_res) && $stable(token_class)
            && $stable(char_out) && $stable(last),
        "stalled token event changed")

    `ASMLEX_ASSERT(a_end_has_no_char,
        tok_valid && (event_res == EV_END) |-> !has_char && (char_out == 8'h00),
        "end event carries a character")

    `ASMLEX_ASSERT(a_string_start_empty,
        tok_valid && (event_res == EV_START) && (token_class == CLS_STRING) |-> !has_char,
        "string start carries a character")

    `ASMLEX_ASSERT(a_punct_closes,
        tok_valid && !tok_stall && (event_res == EV_START) && (token_class == CLS_PUNCT)
            |=> !tok_valid || ((event_res == EV_END) && (token_class == CLS_PUNCT)),
        "punctuation start not followed by its end")

endmodule

bind assembly_line_lexer_top asmlex_checker u_asmlex_checker (.*);

>>> test/assembly_line_lexer_top_tb.sv
// Self-checking testbench for the streaming assembly-line lexer top level.
module assembly_line_lexer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asmlex_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] c;
        logic       eol;
        int         phase;
        bit         drain;
    } char_req_t;

    typedef struct {
        asmlex_kind_t  kind;
        asmlex_class_t cls;
        logic [7:0]    ch;
        logic          has;
        logic          last;
    } lex_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b1;
    logic       char_valid = 1'b0;
    logic       char_stall;
    logic [7:0] char_in = 8'h00;
    logic       line_end = 1'b0;
    logic       tok_valid;
    logic       tok_stall = 1'b0;
    logic [1:0] event_res;
    logic [1:0] token_class;
    logic [7:0] char_out;
    logic       has_char;
    logic       last;

    char_req_t  char_queue[$];
    lex_event_t expected_events[$];
    lex_event_t step_events[$];

    // Lexer state as the testbench sees it.
    asmlex_mode_t lex_state = MODE_IDLE;
    logic         in_single_quote = 1'b0;
    logic         escape_pending = 1'b0;

    int  tx_idle_pct[3] = '{28, 85, 0};
    int  rx_idle_pct[3] = '{85, 28, 0};
    int  rx_stall_pct = 0;
    int  items_queued = 0;
    int  chars_accepted = 0;
    int  events_checked = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  drain_next = 1'b0;

    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string digits  = "0123456789";

    assembly_line_lexer_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_in    (char_in),
        .line_end   (line_end),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .event_res  (event_res),
        .token_class(token_class),
        .char_out   (char_out),
        .has_char   (has_char),
        .last       (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void add_event(input asmlex_kind_t kind, input asmlex_class_t cls,
                                      input logic [7:0] ch, input logic has);
        lex_event_t e;
        e.kind = kind;
        e.cls  = cls;
        e.ch   = has ? ch : 8'h00;
        e.has  = has;
        e.last = 1'b0;
        step_events = {step_events, e};
    endfunction

    function automatic void start_from_idle(input logic [7:0] c);
        if (c == CH_HASH)
        begin
            lex_state = MODE_COMMENT;
        end
        else if (c == CH_SPACE || c == CH_TAB)
        begin
            // Separators only split tokens.
        end
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            add_event(EV_START, CLS_STRING, 8'h00, 1'b0);
            lex_state = MODE_STRING;
            in_single_quote = (c == CH_SQUOTE);
            escape_pending = 1'b0;
        end
        else if (is_letter(c) || c == CH_UNDER)
        begin
            add_event(EV_START, CLS_IDENT, c, 1'b1);
            lex_state = MODE_IDENT;
        end
        else if (c == CH_MINUS || is_numeral(c))
        begin
            add_event(EV_START, CLS_NUMBER, c, 1'b1);
            lex_state = MODE_NUMBER;
        end
        else
        begin
            add_event(EV_START, CLS_PUNCT, c, 1'b1);
            add_event(EV_END, CLS_PUNCT, 8'h00, 1'b0);
        end
    endfunction

    // Works out the token events caused by one accepted character.
    function automatic void lex_char(input logic [7:0] c, input logic eol);
        logic [7:0] closing;
        step_events.delete();
        case (lex_state)
            MODE_COMMENT: ;
            MODE_STRING:
            begin
                closing = in_single_quote ? CH_SQUOTE : CH_DQUOTE;
                if (c == closing && !escape_pending)
                begin
                    add_event(EV_END, CLS_STRING, 8'h00, 1'b0);
                    lex_state = MODE_IDLE;
                    escape_pending = 1'b0;
                end
                else
                begin
                    add_event(EV_APPEND, CLS_STRING, c, 1'b1);
                    escape_pending = (c == CH_BSLASH);
                end
            end
            MODE_IDENT:
            begin
                if (is_letter(c) || is_numeral(c) || c == CH_UNDER)
                    add_event(EV_APPEND, CLS_IDENT, c, 1'b1);
                else
                begin
                    add_event(EV_END, CLS_IDENT, 8'h00, 1'b0);
                    lex_state = MODE_IDLE;
                    start_from_idle(c);
                end
            end
            MODE_NUMBER:
            begin
                if (is_numeral(c))
                    add_event(EV_APPEND, CLS_NUMBER, c, 1'b1);
                else
                begin
                    add_event(EV_END, CLS_NUMBER, 8'h00, 1'b0);
                    lex_state = MODE_IDLE;
                    start_from_idle(c);
                end
            end
            default:
            begin
                lex_state = MODE_IDLE;
                start_from_idle(c);
            end
        endcase

        // The end of a line closes whatever token is still open.
        if (eol)
        begin
            if (lex_state == MODE_IDENT)
                add_event(EV_END, CLS_IDENT, 8'h00, 1'b0);
            else if (lex_state == MODE_NUMBER)
                add_event(EV_END, CLS_NUMBER, 8'h00, 1'b0);
            else if (lex_state == MODE_STRING)
                add_event(EV_END, CLS_STRING, 8'h00, 1'b0);
            lex_state = MODE_IDLE;
            escape_pending = 1'b0;
        end

        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i])
            expected_events = {expected_events, step_events[i]};
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    task automatic push_char(input logic [7:0] c, input logic eol, input int phase);
        char_req_t r;
        r.c = c;
        r.eol = eol;
        r.phase = phase;
        r.drain = drain_next;
        drain_next = 1'b0;
        char_queue = {char_queue, r};
        items_queued++;
    endtask

    task automatic push_line(input string s, input int phase);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1, phase);
    endtask

    // Mostly well-formed token sequences, with some lines of raw bytes.
    task automatic push_random_line(input int phase);
        logic [7:0] line_bytes[$];
        logic [7:0] quote;
        int n_tok;
        int len;
        if ($urandom_range(0, 99) < 15)
        begin
            len = $urandom_range(1, 8);
            repeat (len) line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
        end
        else
        begin
            n_tok = $urandom_range(1, 5);
            for (int t = 0; t < n_tok; t++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        line_bytes = {line_bytes, letters[$urandom_range(0, letters.len() - 1)]};
                        repeat ($urandom_range(0, 4))
                        begin
                            if ($urandom_range(0, 2) == 0)
                                line_bytes = {line_bytes, digits[$urandom_range(0, 9)]};
                            else
                                line_bytes = {line_bytes,
                                    letters[$urandom_range(0, letters.len() - 1)]};
                        end
                    end
                    3, 4:
                    begin
                        if ($urandom_range(0, 2) == 0)
                            line_bytes = {line_bytes, CH_MINUS};
                        else
                            line_bytes = {line_bytes, digits[$urandom_range(0, 9)]};
                        repeat ($urandom_range(0, 3))
                            line_bytes = {line_bytes, digits[$urandom_range(0, 9)]};
                    end
                    5, 6:
                    begin
                        quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                        line_bytes = {line_bytes, quote};
                        repeat ($urandom_range(0, 5))
                        begin
                            case ($urandom_range(0, 4))
                                0: line_bytes = {line_bytes, CH_BSLASH, quote};
                                1: line_bytes = {line_bytes,
                                                 (quote == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE};
                                2: line_bytes = {line_bytes, CH_BSLASH};
                                default: line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
                            endcase
                        end
                        if ($urandom_range(0, 4) != 0)
                            line_bytes = {line_bytes, quote};
                    end
                    7: line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
                    8:
                    begin
                        line_bytes = {line_bytes, CH_HASH};
                        repeat ($urandom_range(0, 4))
                            line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
                        break;
                    end
                    default: line_bytes = {line_bytes, 8'("!" + 8'($urandom_range(0, 14)))};
                endcase
                if ($urandom_range(0, 9) < 7)
                    line_bytes = {line_bytes,
                                  ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE};
            end
        end
        foreach (line_bytes[i])
            push_char(line_bytes[i], i == line_bytes.size() - 1, phase);
    endtask

    // Sender: predicts each accepted request and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_in <= 8'h00;
            line_end <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                lex_char(char_in, line_end);
                chars_accepted++;
            end
            if (!char_valid || !char_stall)
            begin
                if (char_queue.size() > 0
                    && $urandom_range(0, 99) >= tx_idle_pct[char_queue[0].phase]
                    && (!char_queue[0].drain || expected_events.size() == 0))
                begin
                    char_valid <= 1'b1;
                    char_in <= char_queue[0].c;
                    line_end <= char_queue[0].eol;
                    rx_stall_pct <= rx_idle_pct[char_queue[0].phase];
                    void'(char_queue.pop_front());
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted token event and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_stall <= 1'b0;
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("token event with nothing expected: event_res %0h token_class %0h",
                           event_res, token_class);
                    error_count++;
                end
                else
                begin
                    check_field("event_res", expected_events[0].kind, event_res);
                    check_field("token_class", expected_events[0].cls, token_class);
                    check_field("char_out", expected_events[0].ch, char_out);
                    check_field("has_char", expected_events[0].has, has_char);
                    check_field("last", expected_events[0].last, last);
                    void'(expected_events.pop_front());
                    events_checked++;
                end
            end
            tok_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("assembly_line_lexer_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        // Directed lines: identifier and number edges, reprocessing, comments,
        // escaped and closing quotes, control and high bytes, unterminated string.
        drain_next = 1'b1;
        push_line("_a9+-5x", 0);
        push_line("- #c", 0);
        push_line("'a\\'\"'", 0);
        push_char(8'h00, 1'b0, 0);
        push_char(8'hFF, 1'b0, 0);
        push_char(8'h0D, 1'b0, 0);
        push_char(CH_TAB, 1'b0, 0);
        push_char(CH_DQUOTE, 1'b0, 0);
        push_char("b", 1'b1, 0);
        push_char("Z", 1'b1, 0);
        push_line("07", 0);
        for (int p = 0; p < 3; p++)
        begin
            int phase_start;
            phase_start = items_queued;
            drain_next = 1'b1;
            while (items_queued - phase_start < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 39) == 0)
                    drain_next = 1'b1;
                push_random_line(p);
            end
        end

        #1 rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_accepted < items_queued)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d characters lexed, %0d token events checked across three stall mixes",
                 chars_accepted, events_checked);
        if (error_count == 0)
            $display("assembly_line_lexer_top_tb: clean");
        else
            $display("assembly_line_lexer_top_tb: errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/asmlex_pkg.sv
design/asmlex_front.sv
design/asmlex_queue.sv
design/asmlex_back.sv
design/assembly_line_lexer_top.sv
design/asmlex_checker.sv
test/assembly_line_lexer_top_tb.sv
